// ----- src/aln_pkg.sv -----
package aln_pkg;

   // Character codes the normalizer reacts to
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CRET    = 8'h0D;

   // Result kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Line status codes
   localparam logic [1:0] STAT_PLAIN = 2'd0;
   localparam logic [1:0] STAT_LABEL = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_EOF   = 2'd3;

   // Queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] char_out;
      logic [6:0] char_pos;
      logic [1:0] line_status;
      logic       line_overflow;
      logic       last_result;
   } result_type;

   localparam result_type RESULT_NONE = '{
      item_kind:     KIND_CHAR,
      char_out:      8'h00,
      char_pos:      7'd0,
      line_status:   STAT_PLAIN,
      line_overflow: 1'b0,
      last_result:   1'b0
   };

   function automatic logic is_white(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) ||
             (c == CH_FFEED) || (c == CH_CRET);
   endfunction

endpackage

// ----- src/assembly_line_normalizer.sv -----
// Assembly line normalizer.
// Input channel (req_*): one source byte per transaction, or an end-of-file
// mark when req_end_of_file is set. Result channel (rsp_*): normalized
// characters with their line position, and line status words at newline or
// end of file. An input transaction gives zero, one or two results; the last
// result of a transaction carries rsp_last_result.
// Latency: a result is on rsp_* the cycle after its input transaction, when
// the result queue is empty. Throughput: one input transaction per cycle while
// req_ready is high; the line state updates in one short step between the
// input handshake and a 4-entry result queue, draining one result per cycle.
// req_ready is high while the queue has room for two results, so it does not
// depend on rsp_ready in the same cycle. When the receiver stalls, results
// pile up in the queue and req_ready falls once fewer than two slots are free.
// An end of file after a nonempty line costs two queue slots, so a long run
// of those drains at one result per cycle.
// Reset (synchronous, active high) clears the line state and empties the
// queue; no results are pending afterwards.
module assembly_line_normalizer #(
   parameter int unsigned LINE_LEN = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_char_out,
   output logic [6:0] rsp_char_pos,
   output logic [1:0] rsp_line_status,
   output logic       rsp_line_overflow,
   output logic       rsp_last_result
);

   localparam int unsigned WP_W = $clog2(LINE_LEN);
   localparam logic [WP_W-1:0] WP_LIMIT = WP_W'(LINE_LEN - 1);

   // Line state
   logic            line_nonempty_ff, line_nonempty_in;
   logic            last_was_space_ff, last_was_space_in;
   logic            saw_colon_ff, saw_colon_in;
   logic            in_comment_ff, in_comment_in;
   logic [WP_W-1:0] write_position_ff, write_position_in;
   logic            overflowed_ff, overflowed_in;

   // Result queue
   aln_pkg::result_type            queue_ff [aln_pkg::QUEUE_DEPTH];
   logic [aln_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [aln_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [aln_pkg::QCNT_W-1:0]     count_ff, count_in;

   logic                req_fire;
   logic                rsp_fire;
   logic [1:0]          push_n;
   aln_pkg::result_type res0;
   aln_pkg::result_type res1;
   aln_pkg::result_type char_res;
   aln_pkg::result_type stat_res;
   aln_pkg::result_type eof_res;
   logic [1:0]          line_code;
   logic                fits;

   assign req_ready = (count_ff <= aln_pkg::QCNT_W'(aln_pkg::QUEUE_DEPTH - 2));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign fits    = (write_position_ff < WP_LIMIT);

   always_comb begin
      if (in_comment_ff || !line_nonempty_ff) begin
         line_code = aln_pkg::STAT_EMPTY;
      end else if (saw_colon_ff) begin
         line_code = aln_pkg::STAT_LABEL;
      end else begin
         line_code = aln_pkg::STAT_PLAIN;
      end
   end

   // Candidate results
   always_comb begin
      char_res             = aln_pkg::RESULT_NONE;
      char_res.item_kind   = aln_pkg::KIND_CHAR;
      char_res.char_pos    = 7'(write_position_ff);
      char_res.last_result = 1'b1;

      stat_res               = aln_pkg::RESULT_NONE;
      stat_res.item_kind     = aln_pkg::KIND_STATUS;
      stat_res.line_status   = line_code;
      stat_res.line_overflow = overflowed_ff;

      eof_res             = aln_pkg::RESULT_NONE;
      eof_res.item_kind   = aln_pkg::KIND_STATUS;
      eof_res.line_status = aln_pkg::STAT_EOF;
      eof_res.last_result = 1'b1;
   end

   // Line state update and result selection
   always_comb begin
      line_nonempty_in  = line_nonempty_ff;
      last_was_space_in = last_was_space_ff;
      saw_colon_in      = saw_colon_ff;
      in_comment_in     = in_comment_ff;
      write_position_in = write_position_ff;
      overflowed_in     = overflowed_ff;
      push_n            = 2'd0;
      res0              = char_res;
      res1              = eof_res;

      if (req_end_of_file) begin
         if (!in_comment_ff && line_nonempty_ff) begin
            res0   = stat_res;
            push_n = 2'd2;
         end else begin
            res0   = eof_res;
            push_n = 2'd1;
         end
      end else if (req_char_in == aln_pkg::CH_NEWLINE) begin
         res0             = stat_res;
         res0.last_result = 1'b1;
         push_n           = 2'd1;
      end else if (in_comment_ff) begin
         push_n = 2'd0;
      end else if (aln_pkg::is_white(req_char_in)) begin
         if (line_nonempty_ff && !last_was_space_ff) begin
            last_was_space_in = 1'b1;
            res0.char_out     = aln_pkg::CH_SPACE;
            if (fits) begin
               push_n            = 2'd1;
               write_position_in = write_position_ff + 1'b1;
            end else begin
               overflowed_in = 1'b1;
            end
         end
      end else if (req_char_in == aln_pkg::CH_SEMI) begin
         in_comment_in = 1'b1;
      end else begin
         if (req_char_in == aln_pkg::CH_COLON) begin
            saw_colon_in = 1'b1;
         end
         line_nonempty_in  = 1'b1;
         last_was_space_in = 1'b0;
         res0.char_out     = req_char_in;
         if (fits) begin
            push_n            = 2'd1;
            write_position_in = write_position_ff + 1'b1;
         end else begin
            overflowed_in = 1'b1;
         end
      end

      // Newline and end of file close the line
      if (req_end_of_file || (req_char_in == aln_pkg::CH_NEWLINE)) begin
         line_nonempty_in  = 1'b0;
         last_was_space_in = 1'b0;
         saw_colon_in      = 1'b0;
         in_comment_in     = 1'b0;
         write_position_in = '0;
         overflowed_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_nonempty_ff  <= 1'b0;
         last_was_space_ff <= 1'b0;
         saw_colon_ff      <= 1'b0;
         in_comment_ff     <= 1'b0;
         write_position_ff <= '0;
         overflowed_ff     <= 1'b0;
      end else if (req_fire) begin
         line_nonempty_ff  <= line_nonempty_in;
         last_was_space_ff <= last_was_space_in;
         saw_colon_ff      <= saw_colon_in;
         in_comment_ff     <= in_comment_in;
         write_position_ff <= write_position_in;
         overflowed_ff     <= overflowed_in;
      end
   end

   // Queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + aln_pkg::QPTR_W'(push_n);
         count_in  = count_in + aln_pkg::QCNT_W'(push_n);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire && (push_n != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (req_fire && (push_n == 2'd2)) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign rsp_item_kind     = queue_ff[rd_ptr_ff].item_kind;
   assign rsp_char_out      = queue_ff[rd_ptr_ff].char_out;
   assign rsp_char_pos      = queue_ff[rd_ptr_ff].char_pos;
   assign rsp_line_status   = queue_ff[rd_ptr_ff].line_status;
   assign rsp_line_overflow = queue_ff[rd_ptr_ff].line_overflow;
   assign rsp_last_result   = queue_ff[rd_ptr_ff].last_result;

`ifndef SYNTH
   // Queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= aln_pkg::QCNT_W'(aln_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   // Write position never passes the line store limit
   assert property (@(posedge clock) disable iff (reset)
      write_position_ff <= WP_LIMIT)
      else $error("write position beyond line store");

   // End of file or newline always leaves a fresh line
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_end_of_file || (req_char_in == aln_pkg::CH_NEWLINE)) |=>
         !line_nonempty_ff && !in_comment_ff && !overflowed_ff &&
         (write_position_ff == '0))
      else $error("line state not cleared at end of line");

   // A stored character advances the position by one
   assert property (@(posedge clock) disable iff (reset)
      req_fire && (push_n == 2'd1) && (res0.item_kind == aln_pkg::KIND_CHAR) |=>
         write_position_ff == $past(write_position_ff) + 1'b1)
      else $error("write position did not advance");
`endif

endmodule

// ----- sim/aln_line_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels, predicts the normalized stream and compares it.
module aln_line_checker #(
   parameter int unsigned LINE_LEN = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_char_in,
   input  logic              req_end_of_file,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_item_kind,
   input  logic [7:0]        rsp_char_out,
   input  logic [6:0]        rsp_char_pos,
   input  logic [1:0]        rsp_line_status,
   input  logic              rsp_line_overflow,
   input  logic              rsp_last_result,
   output int unsigned       mismatch_count,
   output int unsigned       results_due
);

   // predicted line state
   logic       line_has_text;
   logic       prev_space;
   logic       label_seen;
   logic       comment_mode;
   logic       line_dropped;
   logic [7:0] store_pos;

   aln_pkg::result_type norm_results_due[$];
   int unsigned         fails;

   function automatic logic is_blank(input logic [7:0] c);
      case (c)
         aln_pkg::CH_SPACE, aln_pkg::CH_TAB, aln_pkg::CH_VTAB,
         aln_pkg::CH_FFEED, aln_pkg::CH_CRET: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   task automatic clear_line();
      line_has_text = 1'b0;
      prev_space    = 1'b0;
      label_seen    = 1'b0;
      comment_mode  = 1'b0;
      line_dropped  = 1'b0;
      store_pos     = 8'd0;
   endtask

   function automatic aln_pkg::result_type line_summary();
      aln_pkg::result_type r;
      r = aln_pkg::RESULT_NONE;
      r.item_kind     = aln_pkg::KIND_STATUS;
      r.line_overflow = line_dropped;
      if (comment_mode || !line_has_text)
         r.line_status = aln_pkg::STAT_EMPTY;
      else
         r.line_status = label_seen ? aln_pkg::STAT_LABEL : aln_pkg::STAT_PLAIN;
      return r;
   endfunction

   // Places c in the line store; 0 when the store is full.
   function automatic bit take_slot(input logic [7:0] c,
                                    output aln_pkg::result_type r);
      r = aln_pkg::RESULT_NONE;
      if (store_pos >= LINE_LEN - 1) begin
         line_dropped = 1'b1;
         return 1'b0;
      end
      r.char_out = c;
      r.char_pos = store_pos[6:0];
      store_pos  = store_pos + 8'd1;
      return 1'b1;
   endfunction

   task automatic normalize_byte(input logic [7:0] c, input logic eof);
      aln_pkg::result_type emit [2];
      int                  n;
      int                  i;
      n       = 0;
      emit[0] = aln_pkg::RESULT_NONE;
      emit[1] = aln_pkg::RESULT_NONE;
      if (eof) begin
         if (!comment_mode && line_has_text) begin
            emit[n] = line_summary();
            n++;
         end
         emit[n].item_kind   = aln_pkg::KIND_STATUS;
         emit[n].line_status = aln_pkg::STAT_EOF;
         n++;
         clear_line();
      end else if (c == aln_pkg::CH_NEWLINE) begin
         emit[0] = line_summary();
         n = 1;
         clear_line();
      end else if (comment_mode) begin
         n = 0;
      end else if (is_blank(c)) begin
         if (line_has_text && !prev_space) begin
            if (take_slot(aln_pkg::CH_SPACE, emit[0]))
               n = 1;
            prev_space = 1'b1;
         end
      end else if (c == aln_pkg::CH_SEMI) begin
         comment_mode = 1'b1;
      end else begin
         if (c == aln_pkg::CH_COLON)
            label_seen = 1'b1;
         line_has_text = 1'b1;
         prev_space    = 1'b0;
         if (take_slot(c, emit[0]))
            n = 1;
      end
      if (n > 0)
         emit[n-1].last_result = 1'b1;
      for (i = 0; i < n; i++)
         norm_results_due.push_back(emit[i]);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fails++;
      end
   endtask

   initial begin
      fails = 0;
      clear_line();
   end

   always @(posedge clock) begin
      aln_pkg::result_type want;
      if (reset) begin
         clear_line();
         norm_results_due.delete();
      end else begin
         if (req_valid && req_ready)
            normalize_byte(req_char_in, req_end_of_file);
         if (rsp_valid && rsp_ready) begin
            if (norm_results_due.size() == 0) begin
               $error("result with nothing pending: kind %0d char 0x%0h status %0d",
                      rsp_item_kind, rsp_char_out, rsp_line_status);
               fails++;
            end else begin
               want = norm_results_due.pop_front();
               check_field("item_kind", 32'(want.item_kind), 32'(rsp_item_kind));
               check_field("char_out", 32'(want.char_out), 32'(rsp_char_out));
               check_field("char_pos", 32'(want.char_pos), 32'(rsp_char_pos));
               check_field("line_status", 32'(want.line_status),
                           32'(rsp_line_status));
               check_field("line_overflow", 32'(want.line_overflow),
                           32'(rsp_line_overflow));
               check_field("last_result", 32'(want.last_result),
                           32'(rsp_last_result));
            end
         end
      end
      mismatch_count <= fails;
      results_due    <= norm_results_due.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

// Top of the normalizer bench: clock, reset, stimulus and the verdict.
// All prediction and comparison live in aln_line_checker.
module tb_top;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic [7:0] req_char_in     = 8'h00;
   logic       req_end_of_file = 1'b0;
   logic       rsp_ready       = 1'b0;

   logic       req_ready;
   logic       rsp_valid;
   logic       rsp_item_kind;
   logic [7:0] rsp_char_out;
   logic [6:0] rsp_char_pos;
   logic [1:0] rsp_line_status;
   logic       rsp_line_overflow;
   logic       rsp_last_result;

   int unsigned mismatch_count;
   int unsigned results_due;

   // idle rates in percent, changed per phase
   int unsigned send_idle = 34;
   int unsigned recv_idle = 86;
   int unsigned items_sent = 0;

   assembly_line_normalizer #(
      .LINE_LEN (128)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_char_out      (rsp_char_out),
      .rsp_char_pos      (rsp_char_pos),
      .rsp_line_status   (rsp_line_status),
      .rsp_line_overflow (rsp_line_overflow),
      .rsp_last_result   (rsp_last_result)
   );

   aln_line_checker #(
      .LINE_LEN (128)
   ) u_line_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_end_of_file   (req_end_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_char_out      (rsp_char_out),
      .rsp_char_pos      (rsp_char_pos),
      .rsp_line_status   (rsp_line_status),
      .rsp_line_overflow (rsp_line_overflow),
      .rsp_last_result   (rsp_last_result),
      .mismatch_count    (mismatch_count),
      .results_due       (results_due)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: ready is redrawn every falling edge, one assignment per step.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Hard stop in case the block hangs or drops results.
   initial begin
      #500_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // One transaction on the input channel. Payload goes out at the falling
   // edge, optionally after a random gap with valid low; then valid holds
   // until the rising edge that sees ready.
   task automatic send_item(input logic [7:0] c, input logic eof);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_char_in     <= c;
      req_end_of_file <= eof;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(4))
         0:       return aln_pkg::CH_SPACE;
         1:       return aln_pkg::CH_TAB;
         2:       return aln_pkg::CH_VTAB;
         3:       return aln_pkg::CH_FFEED;
         default: return aln_pkg::CH_CRET;
      endcase
   endfunction

   // Body byte of a source line: mostly mnemonic/operand letters, some
   // whitespace, the odd colon or semicolon, and any byte at all now and then.
   function automatic logic [7:0] body_char();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45)
         return 8'h61 + 8'($urandom_range(25));
      else if (roll < 65)
         return blank_char();
      else if (roll < 70)
         return aln_pkg::CH_COLON;
      else if (roll < 74)
         return aln_pkg::CH_SEMI;
      else
         return 8'($urandom_range(255));
   endfunction

   // One source line. Kinds:
   //  - noise: raw random bytes, end of file marks sprinkled in
   //  - long: enough text to run past the line store, often ending in a colon
   //  - normal: leading whitespace, short body, newline / eof / no terminator
   task automatic send_line(input bit long_line);
      int unsigned pick;
      int unsigned len;
      int unsigned i;
      pick = $urandom_range(99);
      if (!long_line && pick < 8) begin
         repeat ($urandom_range(1, 12))
            send_item(8'($urandom_range(255)), ($urandom_range(15) == 0));
         return;
      end
      repeat ($urandom_range(3))
         send_item(blank_char(), 1'b0);
      if (long_line || pick < 12) begin
         len = $urandom_range(130, 150);
         for (i = 0; i < len; i++) begin
            if (i == len - 1 && $urandom_range(1) == 1)
               send_item(aln_pkg::CH_COLON, 1'b0);
            else if ($urandom_range(9) == 0)
               send_item(aln_pkg::CH_SPACE, 1'b0);
            else
               send_item(8'h41 + 8'($urandom_range(25)), 1'b0);
         end
      end else begin
         len = $urandom_range(0, 20);
         for (i = 0; i < len; i++)
            send_item(body_char(), 1'b0);
      end
      // terminator: eof carries a random byte the block must ignore
      pick = $urandom_range(19);
      if (long_line || pick == 17 || pick == 18)
         send_item(8'($urandom_range(255)), 1'b1);
      else if (pick < 17)
         send_item(aln_pkg::CH_NEWLINE, 1'b0);
   endtask

   // Drop valid and hold off until the checker has nothing outstanding.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (results_due != 0);
   endtask

   initial begin
      // {end_of_file, char_in}
      logic [8:0] opening [24];
      int         k;
      opening = '{
         // leading blanks, label, every whitespace kind collapsed, trailing blank
         {1'b0, aln_pkg::CH_TAB}, {1'b0, aln_pkg::CH_SPACE}, {1'b0, 8'h6C},
         {1'b0, aln_pkg::CH_COLON},
         {1'b0, aln_pkg::CH_VTAB}, {1'b0, aln_pkg::CH_FFEED}, {1'b0, aln_pkg::CH_CRET},
         {1'b0, 8'h78},
         {1'b0, aln_pkg::CH_SPACE}, {1'b0, aln_pkg::CH_NEWLINE},
         // top and bottom of the byte range are ordinary characters
         {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, 8'h00}, {1'b0, aln_pkg::CH_NEWLINE},
         // empty line
         {1'b0, aln_pkg::CH_NEWLINE},
         // comment swallows the colon, line reported empty
         {1'b0, 8'h61}, {1'b0, aln_pkg::CH_SEMI}, {1'b0, aln_pkg::CH_COLON},
         {1'b0, aln_pkg::CH_NEWLINE},
         // eof after text: status then eof; eof on empty line; eof in comment
         {1'b0, 8'h7A}, {1'b1, 8'hFF},
         {1'b1, 8'h00},
         {1'b0, aln_pkg::CH_SEMI}, {1'b1, 8'h5A}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: sender idles a third of the time, receiver mostly stalled.
      send_idle = 34;
      recv_idle = 86;
      for (k = 0; k < 24; k++)
         send_item(opening[k][7:0], opening[k][8]);

      // Let the result side empty out completely before the random part.
      drain_results();

      while (items_sent < 200)
         send_line(1'b0);

      // Phase 2: roles swapped, sender sparse and receiver mostly ready.
      send_idle = 86;
      recv_idle = 34;
      while (items_sent < 370)
         send_line(1'b0);

      // Phase 3: back-to-back both ways; one guaranteed store overflow
      // closed by end of file.
      send_idle = 0;
      recv_idle = 0;
      send_line(1'b1);
      while (items_sent < 550)
         send_line(1'b0);

      drain_results();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
